// ----- hdl/rtpm_pkg.sv -----
// Package for the RTP-to-NTP clock mapper: shared types and constants.
// No dependencies.
`default_nettype none
package rtpm_pkg;
  localparam int NtpW = 64;
  localparam int RtpW = 32;
  localparam int SpanRtpW = 31;
  localparam int ProdW = NtpW + RtpW;   // magnitude (<=2^31) times span_ntp
  localparam int QDepth = 2;

  typedef enum logic {
    FUNC_REPORT = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  typedef enum logic {
    ST_OK    = 1'b0,
    ST_AGAIN = 1'b1
  } status_t;

  // classified work handed from front to back
  typedef struct packed {
    logic            scale;     // needs a division
    logic            neg;       // subtract from anchor
    logic [RtpW-1:0] mag;       // |delta|
    logic [NtpW-1:0] base;      // anchor_ntp at query time
    logic [NtpW-1:0] span_ntp;
    logic [SpanRtpW-1:0] span_rtp;
    logic            status;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV,
    BK_OUT
  } bk_state_t;
endpackage
`default_nettype wire

// ----- hdl/rtpm_front.sv -----
// Front end: accepts words, updates the anchor/slope state and classifies queries.
// Depends on rtpm_pkg.
`default_nettype none
module rtpm_front import rtpm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_func,
  input  wire logic [NtpW-1:0]  in_ntp,
  input  wire logic [RtpW-1:0]  in_rtp,
  output logic                  job_valid,
  output job_t                  job,
  input  wire logic             job_ready
);
  logic            anchor_valid_r, slope_valid_r;
  logic [NtpW-1:0] anchor_ntp_r, span_ntp_r;
  logic [RtpW-1:0] anchor_rtp_r;
  logic [SpanRtpW-1:0] span_rtp_r;
  logic [RtpW-1:0] d_fwd, d_bwd, d_q;
  logic fwd_ok, bwd_ok, take;

  assign in_ready  = job_ready;
  assign job_valid = in_valid;
  assign take      = in_valid && job_ready;
  assign d_fwd = in_rtp - anchor_rtp_r;
  assign d_bwd = anchor_rtp_r - in_rtp;
  assign fwd_ok = d_fwd != '0 && !d_fwd[RtpW-1];
  assign bwd_ok = d_bwd != '0 && !d_bwd[RtpW-1];
  assign d_q = in_rtp - anchor_rtp_r;

  always_comb begin
    job = '0;
    job.status = ST_OK;
    if (func_t'(in_func) == FUNC_REPORT) begin
      if (!anchor_valid_r) job.status = ST_AGAIN;
    end else if (!slope_valid_r || span_rtp_r == '0) begin
      job.status = ST_AGAIN;
    end else begin
      job.scale    = 1'b1;
      job.neg      = d_q[RtpW-1];
      job.mag      = d_q[RtpW-1] ? (RtpW'(0) - d_q) : d_q;  // -2^31 stays 2^31
      job.base     = anchor_ntp_r;
      job.span_ntp = span_ntp_r;
      job.span_rtp = span_rtp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_valid_r <= 1'b0;
      slope_valid_r  <= 1'b0;
      anchor_ntp_r   <= '0;
      anchor_rtp_r   <= '0;
      span_ntp_r     <= '0;
      span_rtp_r     <= '0;
    end else if (take && func_t'(in_func) == FUNC_REPORT) begin
      if (!anchor_valid_r) begin
        anchor_valid_r <= 1'b1;
        anchor_ntp_r   <= in_ntp;
        anchor_rtp_r   <= in_rtp;
      end else if (in_ntp > anchor_ntp_r) begin
        if (fwd_ok) begin
          span_ntp_r    <= in_ntp - anchor_ntp_r;
          span_rtp_r    <= d_fwd[SpanRtpW-1:0];
          anchor_ntp_r  <= in_ntp;
          anchor_rtp_r  <= in_rtp;
          slope_valid_r <= 1'b1;
        end
      end else if (in_ntp < anchor_ntp_r) begin
        if (bwd_ok) begin
          span_ntp_r    <= anchor_ntp_r - in_ntp;
          span_rtp_r    <= d_bwd[SpanRtpW-1:0];
          slope_valid_r <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_slope_needs_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    slope_valid_r |-> anchor_valid_r) else $error("slope without anchor");
  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    slope_valid_r |-> span_rtp_r != '0) else $error("zero span with slope");
  a_scale_ok: assert property (@(posedge clk) disable iff (!rst_n)
    job.scale |-> job.status == ST_OK) else $error("scale job flagged again");
`endif
endmodule
`default_nettype wire

// ----- hdl/rtpm_queue.sv -----
// Two-entry job queue between front and back ends.
// Depends on rtpm_pkg.
`default_nettype none
module rtpm_queue import rtpm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  job_t      wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output job_t      rd_data
);
  job_t       mem_r [QDepth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'(QDepth);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(QDepth)) else $error("queue overflow");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == 2'(QDepth)) |-> wp_r == rp_r) else $error("ptr skew");
  a_empty_no_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> !rd) else $error("read while empty");
`endif
endmodule
`default_nettype wire

// ----- hdl/rtpm_back.sv -----
// Back end: 32x64 multiply in two 32x32 halves, then a radix-2 restoring division
// and the final add or subtract. Holds the result in an output register. Uses rtpm_pkg.
`default_nettype none
module rtpm_back import rtpm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  job_t                 job,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_status,
  output logic [NtpW-1:0]      out_ntp
);
  localparam int CntW = $clog2(ProdW + 1);

  bk_state_t state_r, state_nxt;
  job_t      job_r;
  logic      mstep_r;
  logic [ProdW-1:0] prod_r;     // dividend, shifts into quotient
  logic [SpanRtpW:0] rem_r;
  logic [CntW-1:0] cnt_r;
  logic [NtpW-1:0] res_r;
  logic            stat_r;
  logic [SpanRtpW+1:0] trial;
  logic [63:0] pp;

  assign out_valid  = state_r == BK_OUT;
  assign out_status = stat_r;
  assign out_ntp    = res_r;
  assign job_ready  = state_r == BK_IDLE;
  assign trial = {rem_r, prod_r[ProdW-1]} - {2'b0, job_r.span_rtp};
  assign pp = job_r.mag * (mstep_r ? job_r.span_ntp[63:32] : job_r.span_ntp[31:0]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (job_valid) state_nxt = job.scale ? BK_MUL : BK_OUT;
      BK_MUL:  if (mstep_r) state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == CntW'(ProdW - 1)) state_nxt = BK_OUT;
      BK_OUT:  if (out_ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        job_r   <= job;
        mstep_r <= 1'b0;
        prod_r  <= '0;
        rem_r   <= '0;
        cnt_r   <= '0;
        res_r   <= '0;
        stat_r  <= job.status;
      end
      BK_MUL: begin
        mstep_r <= 1'b1;
        if (!mstep_r) prod_r <= ProdW'(pp);
        else prod_r <= prod_r + {pp, 32'b0};
      end
      BK_DIV: begin
        cnt_r <= cnt_r + CntW'(1);
        if (!trial[SpanRtpW+1]) begin
          rem_r  <= trial[SpanRtpW:0];
          prod_r <= {prod_r[ProdW-2:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[SpanRtpW-1:0], prod_r[ProdW-1]};
          prod_r <= {prod_r[ProdW-2:0], 1'b0};
        end
        if (cnt_r == CntW'(ProdW - 1)) begin
          if (job_r.neg)
            res_r <= job_r.base - {prod_r[NtpW-2:0], !trial[SpanRtpW+1]};
          else
            res_r <= job_r.base + {prod_r[NtpW-2:0], !trial[SpanRtpW+1]};
        end
      end
      BK_OUT: ;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_rem_lt_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> rem_r < {1'b0, job_r.span_rtp}) else $error("remainder");
  a_again_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_ntp == '0) else $error("again with data");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ntp)) else $error("drop");
`endif
endmodule
`default_nettype wire

// ----- hdl/rtp_to_ntp_clock_mapper.sv -----
// RTP-to-NTP clock mapper top level: front end, job queue, divider back end.
// Depends on rtpm_pkg, rtpm_front, rtpm_queue, rtpm_back.
//
// Usage: one input word per sender report (func 0) or per query (func 1);
// every word yields exactly one result word {status, mapped_ntp}.
// Reports update anchor and slope in the front end the cycle they are taken.
// Queries are classified there and handed through a two-entry queue to the
// back end, which multiplies |delta| by span_ntp in two 32x32 halves, then runs a
// 96-step radix-2 restoring division, one quotient bit per cycle.
// The back end handles one word at a time and sets the throughput; the
// front end keeps taking words until the queue is full.
// Reset (rst_n low, synchronous) clears anchor, slope, queue and back end.
// When the receiver holds out_tready low the result stays in the output
// register, the back end waits, and the queue fills, then in_tready drops.
`default_nettype none
module rtp_to_ntp_clock_mapper import rtpm_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,   // report_ntp[63:0], rtp_stamp[95:64]
  input  wire logic         in_tuser,   // func
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // mapped_ntp[63:0]
  output logic              out_tuser   // status
);
  logic f_valid, f_ready, q_valid, q_ready;
  job_t f_job, q_job;

  rtpm_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_func(in_tuser),
    .in_ntp(in_tdata[63:0]), .in_rtp(in_tdata[95:64]),
    .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
  );

  rtpm_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  rtpm_back u_back (
    .clk, .rst_n,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(out_tuser), .out_ntp(out_tdata)
  );
endmodule
`default_nettype wire
